### src/idte_pkg.sv
// Shared types and constants for the ISO date-time to epoch parser
`timescale 1ns / 1ps
package idte_pkg;
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_DATE  = 3'd1;
    localparam logic [2:0] ST_BAD_OFF  = 3'd2;
    localparam logic [2:0] ST_BAD_DATE = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    typedef struct packed {
        logic              is_now;
        logic              only_digits;
        logic              dec_overflow;
        logic [63:0]       dec_value;
        logic              no_date;
        logic              form_ok;
        logic [13:0]       year;
        logic [6:0]        month;
        logic [6:0]        day;
        logic [18:0]       tod;
        logic [12:0]       off_mag;
        logic              off_neg;
        logic signed [63:0] now_val;
    } token_t;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [6:0] two_dig(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] da;
        logic [7:0] db;
        da = a - 8'h30;
        db = b - 8'h30;
        return 7'(da * 8'd10 + db);
    endfunction
endpackage

### src/idte_if.sv
// Valid/ready channel interfaces for the parser
`timescale 1ns / 1ps
interface idte_in_if;
    logic              valid;
    logic              ready;
    logic [7:0]        text_byte;
    logic              last_byte;
    logic signed [63:0] now_seconds;
    modport source (output valid, text_byte, last_byte, now_seconds, input ready);
    modport sink (input valid, text_byte, last_byte, now_seconds, output ready);
endinterface

interface idte_out_if;
    logic              valid;
    logic              ready;
    logic signed [63:0] epoch_seconds;
    logic [2:0]        status;
    modport source (output valid, epoch_seconds, status, input ready);
    modport sink (input valid, epoch_seconds, status, output ready);
endinterface

### src/idte_front.sv
// Byte scanner: tracks the token and emits a summary word on the last byte
`timescale 1ns / 1ps
module idte_front
    import idte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        last_byte,
    input  logic signed [63:0] now_seconds,
    output logic        tok_valid,
    input  logic        tok_ready,
    output token_t      tok
);
    typedef enum logic [3:0] {
        PH_SEARCH, PH_DATE, PH_T, PH_TH1, PH_TH2, PH_TC, PH_TM1, PH_TM2,
        PH_TC2, PH_TS1, PH_OFFSET, PH_ENDED
    } phase_t;
    typedef enum logic [3:0] {
        OF_EMPTY, OF_Z, OF_M, OF_ME, OF_MEZ, OF_MES, OF_MESZ, OF_SIGN,
        OF_H1, OF_H2, OF_COLON, OF_M1, OF_M2, OF_BAD
    } form_t;

    logic [7:0]  rc_reg [10];
    logic [7:0]  rc [10];
    phase_t      ph_reg, ph_next;
    form_t       of_reg, of_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next, day_reg, day_next;
    logic [18:0] tod_reg, tod_next;
    logic [12:0] off_reg, off_next;
    logic        neg_reg, neg_next;
    logic        dig_reg, dig_next;
    logic [63:0] dec_reg, dec_next;
    logic        ovf_reg, ovf_next;
    logic [5:0]  len_reg, len_next;
    logic        acc;
    logic        d;
    logic [7:0]  c;
    logic [3:0]  dv;
    logic        pat;
    logic [6:0]  h8;

    assign in_ready = tok_ready;
    assign acc = in_valid && in_ready;
    assign c = text_byte;
    assign d = is_dig(c);
    assign dv = 4'(c - 8'h30);

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            rc[i] = rc_reg[i + 1];
        end
        rc[9] = c;
        pat = 1'b1;
        for (int i = 0; i < 10; i++)
        begin
            if (i == 4 || i == 7)
            begin
                if (rc[i] != 8'h2D) pat = 1'b0;
            end
            else if (!is_dig(rc[i]))
            begin
                pat = 1'b0;
            end
        end
        h8 = two_dig(rc[8], rc[9]);
    end

    always_comb
    begin
        ph_next = ph_reg;
        of_next = of_reg;
        year_next = year_reg;
        month_next = month_reg;
        day_next = day_reg;
        tod_next = tod_reg;
        off_next = off_reg;
        neg_next = neg_reg;
        len_next = (len_reg < 6'd63) ? len_reg + 6'd1 : len_reg;
        dig_next = dig_reg && d;
        dec_next = dec_reg;
        ovf_next = ovf_reg;
        if (d && !ovf_reg)
        begin
            // limit is (2^63-1-d)/10: 922337203685477580 for digits 0-7, one less for 8 and 9
            if (dec_reg > 64'd922337203685477580 ||
                (dec_reg == 64'd922337203685477580 && dv > 4'd7))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                dec_next = (dec_reg << 3) + (dec_reg << 1) + 64'(dv);
            end
        end
        case (ph_reg)
            PH_SEARCH:
            begin
                if (len_next >= 6'd10 && pat)
                begin
                    year_next = 14'(two_dig(rc[0], rc[1]) * 7'd100) + 14'(two_dig(rc[2], rc[3]));
                    month_next = two_dig(rc[5], rc[6]);
                    day_next = h8;
                    ph_next = PH_DATE;
                end
            end
            PH_DATE, PH_TM2, PH_OFFSET:
            begin
                if (ph_reg != PH_OFFSET && c == 8'h54 && ph_reg == PH_DATE)
                begin
                    ph_next = PH_T;
                end
                else if (ph_reg == PH_TM2 && c == 8'h3A)
                begin
                    ph_next = PH_TC2;
                end
                else if (c == 8'h0A || c == 8'h0D)
                begin
                    ph_next = PH_ENDED;
                end
                else
                begin
                    ph_next = PH_OFFSET;
                    case (of_reg)
                        OF_EMPTY:
                        begin
                            if (c == 8'h5A) of_next = OF_Z;
                            else if (c == 8'h4D) of_next = OF_M;
                            else if (c == 8'h2B || c == 8'h2D)
                            begin
                                of_next = OF_SIGN;
                                neg_next = (c == 8'h2D);
                            end
                            else of_next = OF_BAD;
                        end
                        OF_M: of_next = (c == 8'h45) ? OF_ME : OF_BAD;
                        OF_ME:
                        begin
                            if (c == 8'h5A)
                            begin
                                of_next = OF_MEZ;
                                off_next = 13'd60;
                            end
                            else if (c == 8'h53) of_next = OF_MES;
                            else of_next = OF_BAD;
                        end
                        OF_MES:
                        begin
                            if (c == 8'h5A)
                            begin
                                of_next = OF_MESZ;
                                off_next = 13'd120;
                            end
                            else of_next = OF_BAD;
                        end
                        OF_SIGN: of_next = d ? OF_H1 : OF_BAD;
                        OF_H1:
                        begin
                            if (d)
                            begin
                                of_next = OF_H2;
                                off_next = 13'(h8 * 6'd60);
                            end
                            else of_next = OF_BAD;
                        end
                        OF_H2:
                        begin
                            if (c == 8'h3A) of_next = OF_COLON;
                            else if (d) of_next = OF_M1;
                            else of_next = OF_BAD;
                        end
                        OF_COLON: of_next = d ? OF_M1 : OF_BAD;
                        OF_M1:
                        begin
                            if (d)
                            begin
                                of_next = OF_M2;
                                off_next = off_reg + 13'(h8);
                            end
                            else of_next = OF_BAD;
                        end
                        default: of_next = OF_BAD;
                    endcase
                end
            end
            PH_T:   if (d) ph_next = PH_TH1; else ph_next = PH_ENDED;
            PH_TH1: if (d) ph_next = PH_TH2; else ph_next = PH_ENDED;
            PH_TH2: if (c == 8'h3A) ph_next = PH_TC; else ph_next = PH_ENDED;
            PH_TC:  if (d) ph_next = PH_TM1; else ph_next = PH_ENDED;
            PH_TM1:
            begin
                if (d)
                begin
                    ph_next = PH_TM2;
                    tod_next = 19'(two_dig(rc[5], rc[6]) * 12'd3600) + 19'(h8 * 6'd60);
                end
                else ph_next = PH_ENDED;
            end
            PH_TC2: if (d) ph_next = PH_TS1; else ph_next = PH_ENDED;
            PH_TS1:
            begin
                if (d)
                begin
                    ph_next = PH_OFFSET;
                    tod_next = tod_reg + 19'(h8);
                end
                else ph_next = PH_ENDED;
            end
            default: ;
        endcase
        // broken time forces a bad offset
        if ((ph_reg == PH_T || ph_reg == PH_TH1 || ph_reg == PH_TH2 || ph_reg == PH_TC ||
             ph_reg == PH_TM1 || ph_reg == PH_TC2 || ph_reg == PH_TS1) &&
            ph_next == PH_ENDED)
        begin
            of_next = OF_BAD;
        end
    end

    always_comb
    begin
        tok.is_now = (len_next == 6'd3) && rc[7] == 8'h4E && rc[8] == 8'h4F && rc[9] == 8'h57;
        tok.only_digits = dig_next;
        tok.dec_overflow = ovf_next;
        tok.dec_value = dec_next;
        tok.no_date = (ph_next == PH_SEARCH);
        tok.form_ok = (of_next == OF_EMPTY || of_next == OF_Z || of_next == OF_MEZ ||
                       of_next == OF_MESZ || of_next == OF_H2 || of_next == OF_COLON ||
                       of_next == OF_M2) &&
                      (ph_next == PH_DATE || ph_next == PH_TM2 || ph_next == PH_OFFSET ||
                       ph_next == PH_ENDED);
        tok.year = year_next;
        tok.month = month_next;
        tok.day = day_next;
        tok.tod = tod_next;
        tok.off_mag = off_next;
        tok.off_neg = neg_next;
        tok.now_val = now_seconds;
    end
    assign tok_valid = in_valid && last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 10; i++) rc_reg[i] <= '0;
            ph_reg <= PH_SEARCH;
            of_reg <= OF_EMPTY;
            year_reg <= '0;
            month_reg <= '0;
            day_reg <= '0;
            tod_reg <= '0;
            off_reg <= '0;
            neg_reg <= 1'b0;
            dig_reg <= 1'b1;
            dec_reg <= '0;
            ovf_reg <= 1'b0;
            len_reg <= '0;
        end
        else if (acc)
        begin
            if (last_byte)
            begin
                for (int i = 0; i < 10; i++) rc_reg[i] <= '0;
                ph_reg <= PH_SEARCH;
                of_reg <= OF_EMPTY;
                year_reg <= '0;
                month_reg <= '0;
                day_reg <= '0;
                tod_reg <= '0;
                off_reg <= '0;
                neg_reg <= 1'b0;
                dig_reg <= 1'b1;
                dec_reg <= '0;
                ovf_reg <= 1'b0;
                len_reg <= '0;
            end
            else
            begin
                for (int i = 0; i < 10; i++) rc_reg[i] <= rc[i];
                ph_reg <= ph_next;
                of_reg <= of_next;
                year_reg <= year_next;
                month_reg <= month_next;
                day_reg <= day_next;
                tod_reg <= tod_next;
                off_reg <= off_next;
                neg_reg <= neg_next;
                dig_reg <= dig_next;
                dec_reg <= dec_next;
                ovf_reg <= ovf_next;
                len_reg <= len_next;
            end
        end
    end
endmodule

### src/idte_fifo.sv
// Two-entry queue of token summary words between scanner and converter
`timescale 1ns / 1ps
module idte_fifo
    import idte_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_valid,
    output logic   wr_ready,
    input  token_t wr_data,
    output logic   rd_valid,
    input  logic   rd_ready,
    output token_t rd_data
);
    token_t     mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end
endmodule

### src/idte_back.sv
// Converter: validates the date and computes epoch seconds in three stages
`timescale 1ns / 1ps
module idte_back
    import idte_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   tok_valid,
    output logic   tok_ready,
    input  token_t tok,
    output logic   out_valid,
    input  logic   out_ready,
    output logic signed [63:0] epoch_seconds,
    output logic [2:0] status
);
    // stage 1: status decision and day count pieces
    logic        v1_reg, v2_reg, v3_reg;
    logic        adv1, adv2, adv3;
    logic [2:0]  st1_reg, st2_reg;
    logic        calc1_reg, calc2_reg;
    logic signed [63:0] val1_reg, val2_reg;
    logic [5:0]  era1_reg;
    logic [8:0]  yoe1_reg;
    logic [1:0]  yc1_reg;
    logic [8:0]  doy1_reg;
    logic signed [21:0] adj1_reg, adj2_reg;
    logic signed [31:0] days2_reg;
    logic [2:0]  st3_reg;
    logic signed [63:0] val3_reg;

    logic [13:0] y;
    logic [26:0] qy_prod;
    logic [7:0]  qy;
    logic [6:0]  ry;
    logic        leap;
    logic [4:0]  lim;
    logic        dvalid;
    logic [3:0]  mi;
    logic [8:0]  mbase;
    logic [8:0]  doy;
    logic [2:0]  st;
    logic signed [21:0] adj;
    logic [13:0] yy;
    logic [26:0] qyy_prod;
    logic [7:0]  qyy;
    logic [5:0]  era;
    logic [8:0]  yoe;

    assign adv3 = !v3_reg || out_ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign tok_ready = adv1;

    always_comb
    begin
        y = tok.year;
        // y / 100 by reciprocal, exact for 14-bit y
        qy_prod = 27'(y) * 27'd5243;
        qy = 8'(qy_prod >> 19);
        ry = 7'(y - 14'(qy * 8'd100));
        leap = (y[1:0] == 2'b00 && ry != 7'd0) || (ry == 7'd0 && qy[1:0] == 2'b00);
        mi = tok.month[3:0];
        case (mi)
            4'd2: lim = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: lim = 5'd30;
            default: lim = 5'd31;
        endcase
        dvalid = y >= 14'd1400 && y <= 14'd9999 && tok.month >= 7'd1 && tok.month <= 7'd12 &&
                 tok.day >= 7'd1 && tok.day <= 7'(lim);
        // days before the month, counted from March
        case (mi)
            4'd3: mbase = 9'd0;
            4'd4: mbase = 9'd31;
            4'd5: mbase = 9'd61;
            4'd6: mbase = 9'd92;
            4'd7: mbase = 9'd122;
            4'd8: mbase = 9'd153;
            4'd9: mbase = 9'd184;
            4'd10: mbase = 9'd214;
            4'd11: mbase = 9'd245;
            4'd12: mbase = 9'd275;
            4'd1: mbase = 9'd306;
            4'd2: mbase = 9'd337;
            default: mbase = 9'd0;
        endcase
        doy = mbase + 9'(tok.day) - 9'd1;
        yy = (mi <= 4'd2) ? y - 14'd1 : y;
        qyy_prod = 27'(yy) * 27'd5243;
        qyy = 8'(qyy_prod >> 19);
        era = qyy[7:2];
        yoe = 9'(yy - 14'(era * 9'd400));
        st = ST_OK;
        if (tok.is_now) st = ST_OK;
        else if (tok.only_digits) st = tok.dec_overflow ? ST_OVERFLOW : ST_OK;
        else if (tok.no_date) st = ST_NO_DATE;
        else if (!dvalid) st = ST_BAD_DATE;
        else if (!tok.form_ok) st = ST_BAD_OFF;
        adj = tok.off_neg ? 22'(tok.tod) + 22'(tok.off_mag) * 22'd60
                          : 22'(tok.tod) - 22'(tok.off_mag) * 22'd60;
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && tok_valid)
        begin
            st1_reg <= st;
            calc1_reg <= !tok.is_now && !tok.only_digits && st == ST_OK;
            val1_reg <= tok.is_now ? tok.now_val :
                        (tok.only_digits && st == ST_OK) ? $signed(tok.dec_value) : 64'sd0;
            era1_reg <= era;
            yoe1_reg <= yoe;
            yc1_reg <= qyy[1:0];
            doy1_reg <= doy;
            adj1_reg <= adj;
        end
        if (adv2 && v1_reg)
        begin
            st2_reg <= st1_reg;
            calc2_reg <= calc1_reg;
            val2_reg <= val1_reg;
            days2_reg <= 32'(era1_reg) * 32'd146097 + 32'(yoe1_reg) * 32'd365 +
                         32'(yoe1_reg >> 2) - 32'(yc1_reg) + 32'(doy1_reg) - 32'd719468;
            adj2_reg <= adj1_reg;
        end
        if (adv3 && v2_reg)
        begin
            st3_reg <= st2_reg;
            val3_reg <= calc2_reg ? 64'(days2_reg) * 64'sd86400 + 64'(adj2_reg) : val2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= tok_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign epoch_seconds = val3_reg;
    assign status = st3_reg;
endmodule

### src/iso_datetime_text_to_epoch_core.sv
// A token's summary word is queued on its last byte, then passes the three converter stages.
// Throughput: one byte per cycle while the queue has room; the scanner updates its state as each byte is accepted.
// Results queue in a two-entry buffer feeding a three-stage converter.
// Reset: asynchronous, active low; parser state returns to searching for a date.
`timescale 1ns / 1ps
module iso_datetime_text_to_epoch_core
    import idte_pkg::*;
(
    input logic clk,
    input logic rst_n,
    idte_in_if.sink    in_ch,
    idte_out_if.source out_ch
);
    logic   f_valid, f_ready, q_valid, q_ready;
    token_t f_tok, q_tok;

    idte_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .text_byte(in_ch.text_byte), .last_byte(in_ch.last_byte),
        .now_seconds(in_ch.now_seconds),
        .tok_valid(f_valid), .tok_ready(f_ready), .tok(f_tok)
    );

    idte_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_tok),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_tok)
    );

    idte_back u_back (
        .clk(clk), .rst_n(rst_n),
        .tok_valid(q_valid), .tok_ready(q_ready), .tok(q_tok),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .epoch_seconds(out_ch.epoch_seconds), .status(out_ch.status)
    );

`ifndef NO_ASSERTIONS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status != ST_OK |-> out_ch.epoch_seconds == 64'sd0)
        else $error("error word carries nonzero seconds");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.status <= ST_OVERFLOW)
        else $error("status out of range");
    a_queue_flow: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid && !f_ready |-> !in_ch.ready)
        else $error("byte accepted while queue full");
`endif
endmodule
